// ===== hdl/vmp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmp_pkg: shared types and codes for the vector-matrix product block
// Word formats, opcodes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package vmp_pkg;

  localparam int IDX_W    = 12;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int ACC_W    = 40;
  localparam int RIDX_W   = 6;
  localparam int LEN_W    = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD_VEC = 2'd0,
    OP_LOAD_MAT = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COMMON  = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic [IDX_W-1:0]         index;
    logic signed [ELEM_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [RIDX_W-1:0]       result_index;
    logic signed [ACC_W-1:0] result_value;
    logic                    last;
  } result_t;

  // control from the sequencer into the multiply-accumulate unit
  typedef struct packed {
    logic valid;  // memory read data valid this cycle
    logic last;   // final term of the current dot product
    logic clear;  // zero the accumulator
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage : vmp_pkg
`default_nettype wire

// ===== hdl/vmp_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmp_mac: multiply-accumulate unit
// Registered 16x16 product, then a 40-bit accumulate. Flags the edge at
// which the final term of a dot product has been added.
// ----------------------------------------------------------------------------
module vmp_mac
  import vmp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mac_ctrl_t                ctrl,
  input  wire logic signed [ELEM_W-1:0] vec_data,
  input  wire logic signed [ELEM_W-1:0] mat_data,
  output logic signed [ACC_W-1:0]       acc,
  output logic                          done
);

  logic                     prod_valid;
  logic                     prod_last;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
      prod_last  <= ctrl.valid & ctrl.last;
      done       <= prod_valid & prod_last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= vec_data * mat_data;
  end

  // wraps modulo 2^40
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule : vmp_mac
`default_nettype wire

// ===== hdl/vector_matrix_product.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector_matrix_product: fixed-point matrix-vector multiply (GEMV)
// Loads Q1.15 vector and matrix elements into on-chip memories; a compute
// word streams out one exact 40-bit Q10.30 dot product per result element.
// ----------------------------------------------------------------------------
// Load words: one per cycle while the sequencer is idle (single memory write port).
// Compute word: per result, one term is read per cycle from the memory pair,
//   then the read/multiply/accumulate registers drain; a zero vector_length
//   emits each result without reading any terms.
// Reset: sync, active high; lengths and layout go to 1, memories are not
//   cleared (contents undefined until loaded).
// ----------------------------------------------------------------------------
module vector_matrix_product
  import vmp_pkg::*;
#(
  parameter int MAX_VECTOR = 64,
  parameter int MAX_RESULT = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input words
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire item_t                item,
  // result words
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output result_t                   result,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_value
);

  localparam int MAT_DEPTH = MAX_VECTOR * MAX_RESULT;
  localparam int VW = (MAX_VECTOR > 1) ? $clog2(MAX_VECTOR) : 1;
  localparam int MW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers (to be written only while idle; the block does not enforce it)
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] vector_length;
  logic [LEN_W-1:0] result_length;
  logic             inner_common;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LEN_W'(1);
      result_length <= LEN_W'(1);
      inner_common  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VECTOR_LENGTH: vector_length <= cfg_value;
        REG_RESULT_LENGTH: result_length <= cfg_value;
        REG_INNER_COMMON:  inner_common  <= cfg_value[0];
        default: ;
      endcase
    end
  end

  // lengths clamp to the memory geometry
  logic [LEN_W-1:0] vl_eff;
  logic [LEN_W-1:0] rl_eff;

  assign vl_eff = (32'(vector_length) > MAX_VECTOR) ? LEN_W'(MAX_VECTOR) : vector_length;
  assign rl_eff = (32'(result_length) > MAX_RESULT) ? LEN_W'(MAX_RESULT) : result_length;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t state;
  state_t state_next;

  logic [LEN_W-1:0] row;       // result element being built
  logic [LEN_W-1:0] term;      // term within the dot product
  logic [MW-1:0]    row_base;  // row * vl, result-major layout
  logic [MW-1:0]    addr;      // matrix read address of the current term
  logic [MW-1:0]    row_base_next;

  logic item_fire;
  logic start;
  logic issue;
  logic emit_fire;
  logic term_last;
  logic row_last;
  logic mac_done;

  assign item_fire = item_valid & item_ready;
  assign term_last = (term + LEN_W'(1)) == vl_eff;
  assign row_last  = (row + LEN_W'(1)) == rl_eff;
  assign row_base_next = row_base + MW'(vl_eff);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (vl_eff == '0) ? ST_EMIT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (term_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          if (row_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = (vl_eff == '0) ? ST_EMIT : ST_ISSUE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == ST_IDLE);
    start      = item_fire && (item.op == OP_COMPUTE) && (rl_eff != '0);
    issue      = (state == ST_ISSUE);
    emit_fire  = (state == ST_EMIT) && (!result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // term and address walk; transposed layout strides by result_length
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      term     <= '0;
      row_base <= '0;
      addr     <= '0;
    end else if (start) begin
      row      <= '0;
      term     <= '0;
      row_base <= '0;
      addr     <= '0;
    end else if (issue) begin
      term <= term_last ? '0 : term + LEN_W'(1);
      addr <= addr + (inner_common ? MW'(1) : MW'(rl_eff));
    end else if (emit_fire) begin
      row      <= row + LEN_W'(1);
      row_base <= row_base_next;
      addr     <= inner_common ? row_base_next : MW'(row) + MW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Element memories: one write port (loads), one registered read port
  // --------------------------------------------------------------------------
  logic signed [ELEM_W-1:0] vec_mem [MAX_VECTOR];
  logic signed [ELEM_W-1:0] mat_mem [MAT_DEPTH];
  logic signed [ELEM_W-1:0] vec_q;
  logic signed [ELEM_W-1:0] mat_q;

  always_ff @(posedge clk) begin
    if (item_fire && item.op == OP_LOAD_VEC && 32'(item.index) < MAX_VECTOR) begin
      vec_mem[VW'(item.index)] <= item.value;
    end
    if (issue) begin
      vec_q <= vec_mem[VW'(term)];
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.op == OP_LOAD_MAT && 32'(item.index) < MAT_DEPTH) begin
      mat_mem[MW'(item.index)] <= item.value;
    end
    if (issue) begin
      mat_q <= mat_mem[addr];
    end
  end

  // read data valid flags, aligned with vec_q / mat_q
  logic rd_valid;
  logic rd_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= issue;
      rd_last  <= issue & term_last;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply-accumulate
  // --------------------------------------------------------------------------
  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    mac_ctrl.valid = rd_valid;
    mac_ctrl.last  = rd_last;
    mac_ctrl.clear = (state == ST_IDLE) || emit_fire;
  end

  vmp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .vec_data (vec_q),
    .mat_data (mat_q),
    .acc      (acc),
    .done     (mac_done)
  );

  // --------------------------------------------------------------------------
  // Output register: holds one finished word while the next result is computed or the next item is taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result.result_index <= RIDX_W'(row);
      result.result_value <= acc;
      result.last         <= row_last;
    end
  end

endmodule : vector_matrix_product
`default_nettype wire
